// ===== src/lht_pkg.sv =====
// Shared types and constants for the latency histogram threshold block.
package lht_pkg;

   // Input word kinds carried on req_tuser
   localparam logic [1:0] FUNC_HIT  = 2'd0;
   localparam logic [1:0] FUNC_MISS = 2'd1;
   localparam logic [1:0] FUNC_EVAL = 2'd2;

   // Verdict codes
   localparam logic [1:0] VERDICT_POSSIBLE  = 2'd0;
   localparam logic [1:0] VERDICT_PROBABLY  = 2'd1;
   localparam logic [1:0] VERDICT_MAYBE_NOT = 2'd2;
   localparam logic [1:0] VERDICT_NOT       = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_ONSET_MIN     = 2'd0;
   localparam logic [1:0] CSR_STRONG_MARGIN = 2'd1;
   localparam logic [1:0] CSR_WEAK_MARGIN   = 2'd2;

   // Register reset values
   localparam logic [15:0] ONSET_MIN_RESET     = 16'd3;
   localparam logic [8:0]  STRONG_MARGIN_RESET = 9'd4;
   localparam logic [8:0]  WEAK_MARGIN_RESET   = 9'd2;

   // Width of a bin number on the result word
   localparam int OUT_BIN_WIDTH = 9;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAIN,
      ST_SCAN1,
      ST_S1END,
      ST_VERD,
      ST_SCAN2,
      ST_S2END,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   // Per-bank access control
   typedef struct packed {
      logic sample;   // increment the bin at addr
      logic clear;    // write zero to the bin at addr
   } bank_ctl_type;

endpackage

// ===== src/lht_bank.sv =====
// One histogram bank: count memory with saturating read-modify-write and clear.
module lht_bank #(
   parameter int BINS        = 512,
   parameter int COUNT_WIDTH = 32,
   localparam int AW         = $clog2(BINS)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lht_pkg::bank_ctl_type     ctl,
   input  logic [AW-1:0]             addr,
   output logic [COUNT_WIDTH-1:0]    rd_data
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] mem [BINS];
   logic [COUNT_WIDTH-1:0] rd_ff;

   logic                   s1_v_ff;
   logic [AW-1:0]          s1_bin_ff;
   logic                   wr_v_ff;
   logic [AW-1:0]          wr_bin_ff;
   logic [COUNT_WIDTH-1:0] wr_val_ff;

   logic [COUNT_WIDTH-1:0] cur;
   logic [COUNT_WIDTH-1:0] inc;

   // Forward the write of the previous cycle; the memory read saw old data
   always_comb begin
      cur = (wr_v_ff && (wr_bin_ff == s1_bin_ff)) ? wr_val_ff : rd_ff;
      inc = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);
   end

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         mem[addr] <= '0;
      end else if (s1_v_ff) begin
         mem[s1_bin_ff] <= inc;
      end
      rd_ff <= mem[addr];
   end

   // Increment pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         wr_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= ctl.sample;
         wr_v_ff <= s1_v_ff;
      end
   end

   // Increment pipeline payload
   always_ff @(posedge clock) begin
      s1_bin_ff <= addr;
      wr_bin_ff <= s1_bin_ff;
      wr_val_ff <= inc;
   end

   assign rd_data = rd_ff;

   // A clear sweep never overlaps a pending increment
   a_no_clear_during_inc: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && s1_v_ff))
      else $error("clear overlaps pending increment");

endmodule

// ===== src/lht_scan.sv =====
// Evaluate sequencer: peak/onset scan, threshold scan, clear sweep, result.
module lht_scan #(
   parameter int BINS        = 512,
   parameter int COUNT_WIDTH = 32,
   localparam int AW         = $clog2(BINS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [COUNT_WIDTH-1:0] hit_rd,
   input  logic [COUNT_WIDTH-1:0] miss_rd,
   input  logic [15:0]            onset_min,
   input  logic [8:0]             strong_margin,
   input  logic [8:0]             weak_margin,
   input  logic                   rsp_ready,
   output logic                   idle,
   output logic [AW-1:0]          addr,
   output logic                   clear,
   output logic                   rsp_valid,
   output logic [8:0]             rsp_thr,
   output logic [1:0]             rsp_verdict,
   output logic [8:0]             rsp_peak,
   output logic [8:0]             rsp_onset
);

   localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
   localparam int SW   = ((AW > 9) ? AW : 9) + 1;
   localparam int OW   = (AW > lht_pkg::OUT_BIN_WIDTH) ? AW : lht_pkg::OUT_BIN_WIDTH;
   localparam logic [AW-1:0] LAST = AW'(BINS - 1);

   lht_pkg::state_type state_ff, state_in;
   logic [AW-1:0]          a_ff, a_in;
   logic                   v1_ff, v1_in;
   logic                   v2_ff, v2_in;
   logic [AW-1:0]          idx_ff;

   logic [COUNT_WIDTH-1:0] pk_val_ff, pk_val_in;
   logic [AW-1:0]          peak_ff, peak_in;
   logic [AW-1:0]          onset_ff, onset_in;
   logic                   found_ff, found_in;
   logic [COUNT_WIDTH:0]   best_ff, best_in;
   logic                   best_v_ff, best_v_in;
   logic [AW-1:0]          thr_ff, thr_in;
   logic [1:0]             verd_ff, verd_in;

   logic                   rsp_v_ff, rsp_v_in;
   logic                   load;
   logic [8:0]             rsp_thr_ff, rsp_peak_ff, rsp_onset_ff;
   logic [1:0]             rsp_verd_ff;

   logic [COUNT_WIDTH:0]   sum;
   logic [SW-1:0]          onset_x, strong_sum, weak_sum;
   logic [OW-1:0]          thr_x, peak_x, onset_ox;

   // Margin sums, formed without wrap
   always_comb begin
      onset_x    = SW'(onset_ff);
      strong_sum = SW'(peak_ff) + SW'(strong_margin);
      weak_sum   = SW'(peak_ff) + SW'(weak_margin);
      sum        = {1'b0, hit_rd} + {1'b0, miss_rd};
      thr_x      = OW'(thr_ff);
      peak_x     = OW'(peak_ff);
      onset_ox   = OW'(onset_ff);
   end

   // Next state, scan datapath and outputs
   always_comb begin
      state_in  = state_ff;
      a_in      = a_ff;
      v1_in     = 1'b0;
      v2_in     = 1'b0;
      pk_val_in = pk_val_ff;
      peak_in   = peak_ff;
      onset_in  = onset_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      best_v_in = best_v_ff;
      thr_in    = thr_ff;
      verd_in   = verd_ff;
      idle      = 1'b0;
      clear     = 1'b0;
      load      = 1'b0;
      addr      = a_ff;

      // Data returned for a scan-1 read
      if (v1_ff) begin
         if (hit_rd > pk_val_ff) begin
            pk_val_in = hit_rd;
            peak_in   = idx_ff;
         end
         if ((idx_ff != '0) && !found_ff && (CMPW'(miss_rd) > CMPW'(onset_min))) begin
            onset_in = idx_ff;
            found_in = 1'b1;
         end
      end

      // Data returned for a scan-2 read
      if (v2_ff) begin
         if (!best_v_ff || (sum < best_ff)) begin
            best_in   = sum;
            best_v_in = 1'b1;
            thr_in    = idx_ff;
         end
      end

      case (state_ff)
         lht_pkg::ST_INIT: begin
            clear = 1'b1;
            a_in  = a_ff + AW'(1);
            if (a_ff == LAST) begin
               a_in     = '0;
               state_in = lht_pkg::ST_IDLE;
            end
         end
         lht_pkg::ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               state_in = lht_pkg::ST_DRAIN;
            end
         end
         lht_pkg::ST_DRAIN: begin
            // let the last sample write land before reading
            a_in      = '0;
            pk_val_in = '0;
            peak_in   = '0;
            onset_in  = '0;
            found_in  = 1'b0;
            state_in  = lht_pkg::ST_SCAN1;
         end
         lht_pkg::ST_SCAN1: begin
            v1_in = 1'b1;
            a_in  = a_ff + AW'(1);
            if (a_ff == LAST) begin
               state_in = lht_pkg::ST_S1END;
            end
         end
         lht_pkg::ST_S1END: begin
            state_in = lht_pkg::ST_VERD;
         end
         lht_pkg::ST_VERD: begin
            if (onset_x > strong_sum) begin
               verd_in = lht_pkg::VERDICT_POSSIBLE;
            end else if (onset_x > weak_sum) begin
               verd_in = lht_pkg::VERDICT_PROBABLY;
            end else if (onset_x < weak_sum) begin
               verd_in = lht_pkg::VERDICT_MAYBE_NOT;
            end else begin
               verd_in = lht_pkg::VERDICT_NOT;
            end
            best_v_in = 1'b0;
            thr_in    = '0;
            if (peak_ff < onset_ff) begin
               a_in     = peak_ff;
               state_in = lht_pkg::ST_SCAN2;
            end else begin
               a_in     = '0;
               state_in = lht_pkg::ST_CLEAR;
            end
         end
         lht_pkg::ST_SCAN2: begin
            v2_in = 1'b1;
            a_in  = a_ff + AW'(1);
            if (a_ff == onset_ff - AW'(1)) begin
               state_in = lht_pkg::ST_S2END;
            end
         end
         lht_pkg::ST_S2END: begin
            a_in     = '0;
            state_in = lht_pkg::ST_CLEAR;
         end
         lht_pkg::ST_CLEAR: begin
            clear = 1'b1;
            a_in  = a_ff + AW'(1);
            if (a_ff == LAST) begin
               a_in     = '0;
               state_in = lht_pkg::ST_RESULT;
            end
         end
         lht_pkg::ST_RESULT: begin
            if (!rsp_v_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = lht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lht_pkg::ST_INIT;
            a_in     = '0;
         end
      endcase

      // Output register handshake
      if (load) begin
         rsp_v_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_v_in = 1'b0;
      end else begin
         rsp_v_in = rsp_v_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lht_pkg::ST_INIT;
         a_ff      <= '0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         found_ff  <= 1'b0;
         best_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         a_ff      <= a_in;
         v1_ff     <= v1_in;
         v2_ff     <= v2_in;
         found_ff  <= found_in;
         best_v_ff <= best_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff    <= a_ff;
      pk_val_ff <= pk_val_in;
      peak_ff   <= peak_in;
      onset_ff  <= onset_in;
      best_ff   <= best_in;
      thr_ff    <= thr_in;
      verd_ff   <= verd_in;
      if (load) begin
         rsp_thr_ff   <= thr_x[8:0];
         rsp_verd_ff  <= verd_ff;
         rsp_peak_ff  <= peak_x[8:0];
         rsp_onset_ff <= onset_ox[8:0];
      end
   end

   assign rsp_valid   = rsp_v_ff;
   assign rsp_thr     = rsp_thr_ff;
   assign rsp_verdict = rsp_verd_ff;
   assign rsp_peak    = rsp_peak_ff;
   assign rsp_onset   = rsp_onset_ff;

   // An onset, once found, is never bin zero
   a_onset_nonzero: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> (onset_ff != '0))
      else $error("miss onset recorded at bin zero");

   // Threshold scan stays inside [peak, onset)
   a_scan2_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lht_pkg::ST_SCAN2) |-> ((a_ff >= peak_ff) && (a_ff < onset_ff)))
      else $error("threshold scan outside span");

   // A result appears only out of the result state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !$past(rsp_v_ff)) |-> ($past(state_ff) == lht_pkg::ST_RESULT))
      else $error("result word raised outside result state");

   // Scans never run during a clear sweep
   a_no_scan_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear |-> !(v1_in || v2_in))
      else $error("scan read issued during clear");

endmodule

// ===== src/latency_histogram_threshold_top.sv =====
// Top level: latency histogram threshold calibration with stream ports.
// Samples: a hit or miss sample word is taken every cycle while idle; its count
// is read and registered with its bin, then written back incremented. An evaluate
// word runs a full peak/onset scan, a threshold scan from hit peak up to miss onset
// when the onset lies above the peak, and a full clearing sweep of both count memories,
// plus any wait for the previous result word to leave; no word is taken meanwhile.
// Reset: synchronous; a clearing pass of both memories follows, with no word
// accepted; registers reset to 3, 4 and 2 and are writable.
module latency_histogram_threshold_top #(
   parameter int BINS        = 512,
   parameter int COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] latency
   input  logic [1:0]  req_tuser,   // [1:0] func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [8:0] threshold_bin, [10:9] verdict,
                                    // [19:11] hit_peak_bin, [28:20] miss_onset_bin
   // configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int AW = $clog2(BINS);

   logic [15:0] onset_min_ff;
   logic [8:0]  strong_ff;
   logic [8:0]  weak_ff;

   logic                   req_accept;
   logic                   idle;
   logic                   scan_clear;
   logic [AW-1:0]          scan_addr;
   logic [AW-1:0]          bin;
   logic [AW-1:0]          addr;
   logic [COUNT_WIDTH-1:0] hit_rd, miss_rd;
   lht_pkg::bank_ctl_type  hit_ctl, miss_ctl;

   logic [8:0] thr, peak, onset;
   logic [1:0] verdict;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         onset_min_ff <= lht_pkg::ONSET_MIN_RESET;
         strong_ff    <= lht_pkg::STRONG_MARGIN_RESET;
         weak_ff      <= lht_pkg::WEAK_MARGIN_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            lht_pkg::CSR_ONSET_MIN:     onset_min_ff <= csr_wdata;
            lht_pkg::CSR_STRONG_MARGIN: strong_ff    <= csr_wdata[8:0];
            lht_pkg::CSR_WEAK_MARGIN:   weak_ff      <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // Sample clamp and bank control
   always_comb begin
      req_tready = idle;
      req_accept = req_tvalid && idle;
      if ({1'b0, req_tdata} > 17'(BINS - 1)) begin
         bin = AW'(BINS - 1);
      end else begin
         bin = AW'(req_tdata);
      end
      addr            = idle ? bin : scan_addr;
      hit_ctl.sample  = req_accept && (req_tuser == lht_pkg::FUNC_HIT);
      hit_ctl.clear   = scan_clear;
      miss_ctl.sample = req_accept && (req_tuser == lht_pkg::FUNC_MISS);
      miss_ctl.clear  = scan_clear;
   end

   lht_bank #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_hit_bank (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hit_ctl),
      .addr    (addr),
      .rd_data (hit_rd)
   );

   lht_bank #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_miss_bank (
      .clock   (clock),
      .reset   (reset),
      .ctl     (miss_ctl),
      .addr    (addr),
      .rd_data (miss_rd)
   );

   lht_scan #(.BINS(BINS), .COUNT_WIDTH(COUNT_WIDTH)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .start         (req_accept && (req_tuser == lht_pkg::FUNC_EVAL)),
      .hit_rd        (hit_rd),
      .miss_rd       (miss_rd),
      .onset_min     (onset_min_ff),
      .strong_margin (strong_ff),
      .weak_margin   (weak_ff),
      .rsp_ready     (rsp_tready),
      .idle          (idle),
      .addr          (scan_addr),
      .clear         (scan_clear),
      .rsp_valid     (rsp_tvalid),
      .rsp_thr       (thr),
      .rsp_verdict   (verdict),
      .rsp_peak      (peak),
      .rsp_onset     (onset)
   );

   assign rsp_tdata = {3'b000, onset, peak, verdict, thr};

endmodule
